>>> rtl/json_bracket_balance_checker_top_assert.svh
// ----------------------------------------------------------------------------
// JSON bracket balance checker assertion macros
// Shorthand for clocked assertions with the block's reset as disable.
// ----------------------------------------------------------------------------
`ifndef JSON_BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH
`define JSON_BRACKET_BALANCE_CHECKER_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define JBB_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define JBB_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define JBB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/jbb_pkg.sv
// ----------------------------------------------------------------------------
// JSON bracket balance checker package
// Character codes, verdict codes and shared types of the checker.
// ----------------------------------------------------------------------------
package jbb_pkg;

	localparam int DepthBitsDefault = 16;

	localparam logic [15:0] MaxSizeReset = 16'hFFFF;
	localparam logic [16:0] TotalMax     = 17'd65536;
	localparam logic [16:0] MinLength    = 17'd2;

	localparam logic [7:0] CharLbrace = 8'h7B;
	localparam logic [7:0] CharRbrace = 8'h7D;
	localparam logic [7:0] CharLbrack = 8'h5B;
	localparam logic [7:0] CharRbrack = 8'h5D;
	localparam logic [7:0] CharBslash = 8'h5C;
	localparam logic [7:0] CharQuote  = 8'h22;

	typedef enum logic [2:0] {
		REASON_OK         = 3'd0,
		REASON_OPENER     = 3'd1,
		REASON_CLOSER     = 3'd2,
		REASON_UNDERFLOW  = 3'd3,
		REASON_UNBALANCED = 3'd4,
		REASON_LENGTH     = 3'd5
	} reason_t;

	// One byte handed from the input register to the scanner.
	typedef struct packed {
		logic       fire;
		logic [7:0] data;
		logic       last;
	} step_t;

	// Verdict for one message.
	typedef struct packed {
		logic        pass;
		reason_t     reason;
		logic [16:0] length;
	} verdict_t;

endpackage

>>> rtl/json_bracket_balance_checker_top.sv
// ----------------------------------------------------------------------------
// JSON bracket balance checker
// Byte-serial bracket, brace and string balance check of JSON-like messages.
// ----------------------------------------------------------------------------
// Takes one message byte per clock cycle, sustained, for as long as results
// are taken. A byte goes into an input register, is scanned against the
// message state in the next cycle, and on the byte marked last the verdict
// lands in the result register. Only a last byte that meets a full, stalled
// result register holds the input side; all other bytes flow through
// regardless. max_message_size is written through cfg_we and cfg_wdata; the
// user must do so only while idle, as the block does not enforce it.
module json_bracket_balance_checker_top #(
	parameter int DEPTH_BITS = jbb_pkg::DepthBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        valid_res,
	output logic [2:0]  reason,
	output logic [16:0] message_length
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              last_s1;
	logic [15:0]       max_size_q;
	logic              res_valid_q;
	jbb_pkg::verdict_t res_q;
	jbb_pkg::verdict_t verdict;
	jbb_pkg::step_t    step;
	logic              advance;

	// A last byte needs room in the result register; other bytes never wait.
	assign advance  = valid_s1 && (!last_s1 || !res_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign step.fire = advance;
	assign step.data = byte_s1;
	assign step.last = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= jbb_pkg::MaxSizeReset;
		end else if (cfg_we) begin
			max_size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= last_byte;
		end
	end

	jbb_scan #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.max_size(max_size_q),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			res_q <= verdict;
		end
	end

	assign out_valid      = res_valid_q;
	assign valid_res      = res_q.pass;
	assign reason         = res_q.reason;
	assign message_length = res_q.length;

endmodule

>>> rtl/jbb_scan.sv
// ----------------------------------------------------------------------------
// JSON bracket balance scanner
// Holds the per-message state and forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module jbb_scan #(
	parameter int DEPTH_BITS = jbb_pkg::DepthBitsDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  jbb_pkg::step_t   step,
	input  logic [15:0]      max_size,
	output jbb_pkg::verdict_t verdict
);

	localparam logic [32:0] DepthMax = 33'((64'd1 << DEPTH_BITS) - 64'd1);
	localparam logic [DEPTH_BITS-1:0] DepthOne = {{(DEPTH_BITS-1){1'b0}}, 1'b1};
	localparam logic [DEPTH_BITS-1:0] DepthSat = {DEPTH_BITS{1'b1}};

	logic [DEPTH_BITS-1:0] brace_q, brace_n;
	logic [DEPTH_BITS-1:0] brack_q, brack_n;
	logic                  str_q, str_n;
	logic                  esc_q, esc_n;
	logic [16:0]           total_q, total_n;
	logic                  opener_q, opener_n;
	logic                  under_q, under_n;
	logic                  closer_ok;
	jbb_pkg::reason_t      reason_n;

	always_comb begin
		brace_n  = brace_q;
		brack_n  = brack_q;
		str_n    = str_q;
		esc_n    = esc_q;
		total_n  = total_q;
		opener_n = opener_q;
		under_n  = under_q;

		if (total_q == 17'd0) begin
			opener_n = (step.data == jbb_pkg::CharLbrace) ||
				(step.data == jbb_pkg::CharLbrack);
		end
		if (total_q != jbb_pkg::TotalMax) begin
			total_n = total_q + 17'd1;
		end

		if (esc_q) begin
			esc_n = 1'b0;
		end else if (step.data == jbb_pkg::CharBslash) begin
			esc_n = 1'b1;
		end else if (step.data == jbb_pkg::CharQuote) begin
			str_n = !str_q;
		end else if (!str_q) begin
			case (step.data)
				jbb_pkg::CharLbrace: begin
					if (brace_q != DepthSat) brace_n = brace_q + DepthOne;
				end
				jbb_pkg::CharRbrace: begin
					if (brace_q == '0) under_n = 1'b1;
					else brace_n = brace_q - DepthOne;
				end
				jbb_pkg::CharLbrack: begin
					if (brack_q != DepthSat) brack_n = brack_q + DepthOne;
				end
				jbb_pkg::CharRbrack: begin
					if (brack_q == '0) under_n = 1'b1;
					else brack_n = brack_q - DepthOne;
				end
				default: begin
				end
			endcase
		end
	end

	// The closer check looks at the raw byte, even when it is escaped.
	assign closer_ok = (step.data == jbb_pkg::CharRbrace) ||
		(step.data == jbb_pkg::CharRbrack);

	always_comb begin
		if (!opener_n) begin
			reason_n = jbb_pkg::REASON_OPENER;
		end else if (!closer_ok) begin
			reason_n = jbb_pkg::REASON_CLOSER;
		end else if ({16'd0, total_n} > DepthMax) begin
			reason_n = jbb_pkg::REASON_LENGTH;
		end else if (under_n) begin
			reason_n = jbb_pkg::REASON_UNDERFLOW;
		end else if ((brace_n != '0) || (brack_n != '0) || str_n) begin
			reason_n = jbb_pkg::REASON_UNBALANCED;
		end else if ((total_n < jbb_pkg::MinLength) || (total_n > {1'b0, max_size})) begin
			reason_n = jbb_pkg::REASON_LENGTH;
		end else begin
			reason_n = jbb_pkg::REASON_OK;
		end
	end

	assign verdict.pass   = (reason_n == jbb_pkg::REASON_OK);
	assign verdict.reason = reason_n;
	assign verdict.length = total_n;

	// All message state clears once the last byte has been scanned.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brace_q  <= '0;
			brack_q  <= '0;
			str_q    <= 1'b0;
			esc_q    <= 1'b0;
			total_q  <= '0;
			opener_q <= 1'b0;
			under_q  <= 1'b0;
		end else if (step.fire) begin
			if (step.last) begin
				brace_q  <= '0;
				brack_q  <= '0;
				str_q    <= 1'b0;
				esc_q    <= 1'b0;
				total_q  <= '0;
				opener_q <= 1'b0;
				under_q  <= 1'b0;
			end else begin
				brace_q  <= brace_n;
				brack_q  <= brack_n;
				str_q    <= str_n;
				esc_q    <= esc_n;
				total_q  <= total_n;
				opener_q <= opener_n;
				under_q  <= under_n;
			end
		end
	end

endmodule

>>> rtl/jbb_checker.sv
// ----------------------------------------------------------------------------
// JSON bracket balance checker port assertions
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`include "json_bracket_balance_checker_top_assert.svh"

module jbb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        valid_res,
	input logic [2:0]  reason,
	input logic [16:0] message_length
);

	// A held result keeps its value until it is taken.
	`JBB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(valid_res) && $stable(reason) && $stable(message_length), "stalled result changed")

	// The pass flag and the reason code tell the same story.
	`JBB_ASSERT_IMPLY(a_pass_reason, out_valid, valid_res == (reason == jbb_pkg::REASON_OK), "pass flag disagrees with reason")

	// A passing message has at least two bytes and fits the largest register value.
	`JBB_ASSERT_IMPLY(a_pass_length, out_valid && valid_res, (message_length >= 17'd2) && (message_length <= 17'd65535), "passing message has bad length")

	// The input side waits only behind a result that is itself held up.
	`JBB_ASSERT_ALWAYS(a_stall_cause, !in_stall || (out_valid && out_stall), "input stalled without a stalled result")

endmodule

bind json_bracket_balance_checker_top jbb_checker u_jbb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.valid_res     (valid_res),
	.reason        (reason),
	.message_length(message_length)
);

>>> tb/jbb_balance_monitor.sv
// ----------------------------------------------------------------------------
// JSON bracket balance verdict monitor
// Watches the byte and verdict channels of the bracket balance checker. It
// keeps its own copy of the message state, predicts the verdict of every
// message from the words taken in, and compares each verdict taken out
// against the oldest prediction.
// ----------------------------------------------------------------------------
module jbb_balance_monitor #(
	parameter int DEPTH_BITS = jbb_pkg::DepthBitsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        valid_res,
	input  logic [2:0]  reason,
	input  logic [16:0] message_length,
	output int          failures,
	output int          outstanding,
	output int          verdicts_seen,
	output int          passes_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// Longest message that cannot saturate a depth counter.
	localparam longint unsigned DepthLimit = (64'd1 << DEPTH_BITS) - 64'd1;

	logic [15:0]           size_limit;
	logic [DEPTH_BITS-1:0] brace_cnt;
	logic [DEPTH_BITS-1:0] brack_cnt;
	logic                  in_string;
	logic                  escape_next;
	logic                  opened_ok;
	logic                  went_negative;
	logic [16:0]           byte_count;

	jbb_pkg::verdict_t verdict_q[$];
	int       fail_cnt = 0;
	int       verdict_cnt = 0;
	int       pass_cnt = 0;

	function automatic void clear_message();
		brace_cnt = '0;
		brack_cnt = '0;
		in_string = 1'b0;
		escape_next = 1'b0;
		opened_ok = 1'b0;
		went_negative = 1'b0;
		byte_count = '0;
	endfunction

	function automatic void scan_byte(input logic [7:0] b, input logic is_last);
		jbb_pkg::verdict_t v;
		if (byte_count == '0)
			opened_ok = (b == jbb_pkg::CharLbrace || b == jbb_pkg::CharLbrack);
		if (byte_count != jbb_pkg::TotalMax)
			byte_count++;

		if (escape_next)
			escape_next = 1'b0;
		else if (b == jbb_pkg::CharBslash)
			escape_next = 1'b1;
		else if (b == jbb_pkg::CharQuote)
			in_string = !in_string;
		else if (!in_string) begin
			case (b)
				jbb_pkg::CharLbrace: if (brace_cnt != '1) brace_cnt++;
				jbb_pkg::CharLbrack: if (brack_cnt != '1) brack_cnt++;
				jbb_pkg::CharRbrace: begin
					if (brace_cnt == '0)
						went_negative = 1'b1;
					else
						brace_cnt--;
				end
				jbb_pkg::CharRbrack: begin
					if (brack_cnt == '0)
						went_negative = 1'b1;
					else
						brack_cnt--;
				end
				default: ;
			endcase
		end

		if (is_last) begin
			// The closer check looks at the raw byte, escaped or not.
			if (!opened_ok)
				v.reason = jbb_pkg::REASON_OPENER;
			else if (b != jbb_pkg::CharRbrace && b != jbb_pkg::CharRbrack)
				v.reason = jbb_pkg::REASON_CLOSER;
			else if (byte_count > DepthLimit)
				v.reason = jbb_pkg::REASON_LENGTH;
			else if (went_negative)
				v.reason = jbb_pkg::REASON_UNDERFLOW;
			else if (brace_cnt != '0 || brack_cnt != '0 || in_string)
				v.reason = jbb_pkg::REASON_UNBALANCED;
			else if (byte_count < jbb_pkg::MinLength || byte_count > {1'b0, size_limit})
				v.reason = jbb_pkg::REASON_LENGTH;
			else
				v.reason = jbb_pkg::REASON_OK;
			v.pass = (v.reason == jbb_pkg::REASON_OK);
			v.length = byte_count;
			verdict_q.insert(verdict_q.size(), v);
			clear_message();
		end
	endfunction

	function automatic void check_verdict();
		jbb_pkg::verdict_t want;
		if (verdict_q.size() == 0) begin
			fail_cnt++;
			$display("%0t: verdict with none expected: valid_res %0b reason %0d length %0d",
				$time, valid_res, reason, message_length);
		end else begin
			want = verdict_q.pop_front();
			verdict_cnt++;
			if (valid_res === 1'b1)
				pass_cnt++;
			if (valid_res !== want.pass) begin
				fail_cnt++;
				$display("%0t: valid_res expected %0b actual %0b", $time, want.pass, valid_res);
			end
			if (reason !== want.reason) begin
				fail_cnt++;
				$display("%0t: reason expected %0d actual %0d", $time, want.reason, reason);
			end
			if (message_length !== want.length) begin
				fail_cnt++;
				$display("%0t: message_length expected %0d actual %0d",
					$time, want.length, message_length);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit = jbb_pkg::MaxSizeReset;
			clear_message();
			verdict_q.delete();
		end else begin
			if (cfg_we)
				size_limit = cfg_wdata;
			if (out_valid && !out_stall)
				check_verdict();
			if (in_valid && !in_stall)
				scan_byte(in_byte, last_byte);
		end
		failures <= fail_cnt;
		outstanding <= verdict_q.size();
		verdicts_seen <= verdict_cnt;
		passes_seen <= pass_cnt;
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// JSON bracket balance checker testbench
// Sends directed messages and a stream of mostly well-formed random messages
// with occasional corruption, under several maximum sizes and mixes of
// sender gaps and receiver stalls. The monitor beside the block predicts and
// checks every verdict.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 1_000_000;
	localparam int BytesPerLimit = 100;
	localparam int LimitCount = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic [7:0]  in_byte = '0;
	logic        last_byte = 1'b0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire         valid_res;
	wire  [2:0]  reason;
	wire  [16:0] message_length;

	int failures;
	int outstanding;
	int verdicts_seen;
	int passes_seen;

	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int cycle_count = 0;
	int bytes_sent = 0;
	int messages_sent = 0;

	logic [7:0]  msg_bytes[$];
	logic [7:0]  closers[$];
	logic [15:0] size_plan[LimitCount];

	json_bracket_balance_checker_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.valid_res      (valid_res),
		.reason         (reason),
		.message_length (message_length)
	);

	jbb_balance_monitor monitor (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.valid_res      (valid_res),
		.reason         (reason),
		.message_length (message_length),
		.failures       (failures),
		.outstanding    (outstanding),
		.verdicts_seen  (verdicts_seen),
		.passes_seen    (passes_seen)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Timeout after %0d cycles with %0d verdicts outstanding",
				cycle_count, outstanding);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// The word is taken at the first edge where in_stall is low; in_stall
	// read just after the edge still holds the value seen by that edge.
	task automatic send_byte(input logic [7:0] b, input logic is_last);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		last_byte <= is_last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_message();
		int i;
		for (i = 0; i < msg_bytes.size(); i++)
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
		messages_sent++;
	endtask

	function automatic void add_byte(input logic [7:0] c);
		msg_bytes.insert(msg_bytes.size(), c);
	endfunction

	task automatic send_text(input string s);
		int i;
		msg_bytes.delete();
		for (i = 0; i < s.len(); i++)
			add_byte(s[i]);
		send_message();
	endtask

	// The monitor's count is registered, so look only after an edge.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	task automatic write_size_limit(input logic [15:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(255));
		while (c == jbb_pkg::CharLbrace || c == jbb_pkg::CharRbrace ||
			c == jbb_pkg::CharLbrack || c == jbb_pkg::CharRbrack ||
			c == jbb_pkg::CharBslash || c == jbb_pkg::CharQuote);
		return c;
	endfunction

	function automatic logic [7:0] special_byte();
		case ($urandom_range(5))
			0: return jbb_pkg::CharLbrace;
			1: return jbb_pkg::CharRbrace;
			2: return jbb_pkg::CharLbrack;
			3: return jbb_pkg::CharRbrack;
			4: return jbb_pkg::CharBslash;
			default: return jbb_pkg::CharQuote;
		endcase
	endfunction

	function automatic void push_opener();
		logic [7:0] c;
		c = $urandom_range(1) ? jbb_pkg::CharLbrace : jbb_pkg::CharLbrack;
		add_byte(c);
		closers.insert(closers.size(),
			c == jbb_pkg::CharLbrace ? jbb_pkg::CharRbrace : jbb_pkg::CharRbrack);
	endfunction

	// Builds a nested message with strings and escapes, then now and then
	// corrupts it or throws it away for a short run of noise.
	task automatic build_message();
		int target;
		int n;
		int idx;
		msg_bytes.delete();
		closers.delete();
		target = int'($urandom_range(1, 24));
		push_opener();
		while (msg_bytes.size() < target) begin
			case ($urandom_range(9))
				0, 1: if (closers.size() < 6) push_opener();
				2: if (closers.size() > 1) add_byte(closers.pop_back());
				3: begin
					add_byte(jbb_pkg::CharQuote);
					n = int'($urandom_range(4));
					repeat (n) begin
						case ($urandom_range(3))
							0: begin
								add_byte(jbb_pkg::CharBslash);
								add_byte(8'($urandom_range(255)));
							end
							1: add_byte($urandom_range(1) ? jbb_pkg::CharRbrace :
								jbb_pkg::CharLbrack);
							default: add_byte(plain_byte());
						endcase
					end
					add_byte(jbb_pkg::CharQuote);
				end
				4: begin
					add_byte(jbb_pkg::CharBslash);
					add_byte($urandom_range(1) ? special_byte() : plain_byte());
				end
				default: add_byte(plain_byte());
			endcase
		end
		while (closers.size() > 0)
			add_byte(closers.pop_back());

		if ($urandom_range(3) == 0) begin
			idx = int'($urandom_range(msg_bytes.size() - 1));
			case ($urandom_range(4))
				0: msg_bytes[idx] = 8'($urandom_range(255));
				1: msg_bytes[idx] = special_byte();
				2: if (msg_bytes.size() > 1) msg_bytes.delete(idx);
				3: add_byte(special_byte());
				default: begin
					msg_bytes.delete();
					n = int'($urandom_range(1, 8));
					repeat (n) begin
						if ($urandom_range(1))
							add_byte(special_byte());
						else
							add_byte(8'($urandom_range(255)));
					end
				end
			endcase
		end
	endtask

	initial begin
		int p;
		int phase_bytes;

		size_plan[0] = 16'd0;
		size_plan[1] = 16'd1;
		size_plan[2] = 16'd2;
		size_plan[3] = 16'($urandom_range(3, 40));
		size_plan[4] = 16'hFFFF;
		size_plan[5] = 16'($urandom_range(3, 40));
		size_plan[6] = 16'($urandom_range(65535));
		size_plan[7] = 16'($urandom_range(8, 30));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		tx_idle_pct = 11;
		rx_stall_pct = 53;

		send_text("{}");
		send_text("[]");
		// A one-word message is its own opener and closer.
		send_text("{");
		send_text("]");
		send_text("[}");
		// An escaped closer still counts as the closer, but not for depth.
		send_text("[\\]");
		send_text("{\"}");
		send_text("[{]}");
		msg_bytes = '{8'hFF, 8'h00};
		send_message();
		msg_bytes = '{jbb_pkg::CharLbrace, 8'h80, jbb_pkg::CharRbrace};
		send_message();

		for (p = 0; p < LimitCount; p++) begin
			if (p < 3) begin
				tx_idle_pct = 11;
				rx_stall_pct = 53;
			end else if (p < 6) begin
				tx_idle_pct = 53;
				rx_stall_pct = 11;
			end else begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			write_size_limit(size_plan[p]);
			phase_bytes = 0;
			while (phase_bytes < BytesPerLimit) begin
				build_message();
				phase_bytes += msg_bytes.size();
				send_message();
				if ($urandom_range(24) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);

		$display("Sent %0d words in %0d messages under %0d size limits and three idle mixes.",
			bytes_sent, messages_sent, LimitCount);
		$display("Checked %0d verdicts: %0d accepted, %0d rejected, %0d mismatches.",
			verdicts_seen, passes_seen, verdicts_seen - passes_seen, failures);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
